/* design/asi_pkg.sv */
package asi_pkg;

    // scan phase of the start code search
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_START  = 2'd1,
        PH_PASS   = 2'd2
    } t_phase;

    // source of an output byte
    typedef enum logic [1:0] {
        SRC_SEI  = 2'd0,
        SRC_HOLD = 2'd1,
        SRC_BYTE = 2'd2
    } t_src;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit;
        t_src src;
        logic last_byte;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic plan_sei_pre;
        logic plan_hold;
        logic plan_byte;
        logic plan_sei_post;
        logic sei_last;
        logic hold_last;
        logic out_free;
    } t_dp_stat;

    localparam logic [7:0] H264_TYPE_MASK  = 8'h1F;
    localparam logic [5:0] HEVC_TYPE_MASK  = 6'h3F;
    localparam logic [4:0] H264_TYPE_SPS   = 5'd7;
    localparam logic [4:0] H264_TYPE_PPS   = 5'd8;
    localparam logic [4:0] H264_TYPE_AUD   = 5'd9;
    localparam logic [5:0] HEVC_TYPE_VPS   = 6'd32;
    localparam logic [5:0] HEVC_TYPE_SPS   = 6'd33;
    localparam logic [5:0] HEVC_TYPE_PPS   = 6'd34;
    localparam logic [5:0] HEVC_TYPE_AUD   = 6'd35;

    localparam logic [7:0] START_CODE_BYTE = 8'h01;
    localparam logic [1:0] HOLD_ZERO_MAX   = 2'd3;
    localparam logic [1:0] START_MIN_ZEROS = 2'd2;

    // parameter set or delimiter header
    function automatic logic hdr_is_setup_nal(input logic hevc, input logic [7:0] hdr);
        logic [4:0] t264;
        logic [5:0] t265;
        t264 = 5'(hdr & H264_TYPE_MASK);
        t265 = hdr[6:1] & HEVC_TYPE_MASK;
        if (hevc) begin
            return (t265 == HEVC_TYPE_VPS) || (t265 == HEVC_TYPE_SPS) ||
                   (t265 == HEVC_TYPE_PPS) || (t265 == HEVC_TYPE_AUD);
        end
        return (t264 == H264_TYPE_SPS) || (t264 == H264_TYPE_PPS) ||
               (t264 == H264_TYPE_AUD);
    endfunction

endpackage

/* design/asi_in_if.sv */
interface asi_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_in;
    logic       last_in;

    modport source (output valid, output kind, output byte_in, output last_in, input ready);
    modport sink   (input valid, input kind, input byte_in, input last_in, output ready);
endinterface

/* design/asi_out_if.sv */
interface asi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       from_sei;
    logic       packet_end;
    logic       sei_dropped;
    logic       run_last;

    modport source (output valid, output byte_out, output from_sei, output packet_end,
                    output sei_dropped, output run_last, input ready);
    modport sink   (input valid, input byte_out, input from_sei, input packet_end,
                    input sei_dropped, input run_last, output ready);
endinterface

/* design/annexb_sei_nal_inserter.sv */
// annex b sei inserter
//
// i_item carries requests of two kinds. kind 0 appends one byte of an sei nal
// to the internal buffer (SEI_DEPTH bytes; extra bytes are dropped and the
// packet then passes untouched with sei_dropped set on its last byte). kind 1
// carries one byte of a coded packet, last_in on its final byte.
// o_res carries the output packet bytes; the buffered sei is placed ahead of
// the start code of the first nal that is not a parameter set or delimiter,
// or at the packet end if no such nal shows up. run_last marks the last byte
// that a request produced. i_cfg_we / i_cfg_wdata select h.265 (1) or h.264.
//
// timing: a request is taken while the sequencer is idle; the bytes it
// produces (0 to SEI_DEPTH + 5) leave one per cycle through the single output
// register while the receiver is ready; the next request waits for the last.
// the sei buffer read port feeds one byte per cycle during unstalled insertion.
// reset clears the scan state, empties the sei buffer and selects h.264.
// when the receiver stalls, the output register holds its byte, emission
// pauses and i_item.ready stays low until the current request is done.
module annexb_sei_nal_inserter
    import asi_pkg::*;
#(
    parameter int SEI_DEPTH = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    asi_in_if.sink     i_item,
    asi_out_if.source  o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ctrl_ready;

    // sequencer: picks which segment goes out next
    asi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_stat  (stat),
        .o_ready (ctrl_ready),
        .o_cmd   (cmd)
    );

    // scan state, sei buffer, held bytes and output register
    asi_dp #(
        .SEI_DEPTH (SEI_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_item.kind),
        .i_byte_in     (i_item.byte_in),
        .i_last_in     (i_item.last_in),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_byte_out    (o_res.byte_out),
        .o_from_sei    (o_res.from_sei),
        .o_packet_end  (o_res.packet_end),
        .o_sei_dropped (o_res.sei_dropped),
        .o_run_last    (o_res.run_last)
    );

    // requests are taken only between runs of output bytes
    assign i_item.ready = ctrl_ready;

endmodule

/* design/asi_ctrl.sv */
module asi_ctrl
    import asi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SEI  = 2'd1,
        ST_HOLD = 2'd2,
        ST_BYTE = 2'd3
    } t_state;

    t_state r_state, n_state;
    logic   r_need_pre, n_need_pre;
    logic   r_need_hold, n_need_hold;
    logic   r_need_byte, n_need_byte;
    logic   r_need_post, n_need_post;
    logic   seg_last;
    t_state after_seg;

    // segment order: sei before, held bytes, current byte, sei after
    function automatic t_state pick(input logic pre, input logic hold, input logic cur,
                                    input logic post);
        priority if (pre)  return ST_SEI;
        else if (hold)     return ST_HOLD;
        else if (cur)      return ST_BYTE;
        else if (post)     return ST_SEI;
        else               return ST_IDLE;
    endfunction

    always_comb begin
        n_state     = r_state;
        n_need_pre  = r_need_pre;
        n_need_hold = r_need_hold;
        n_need_byte = r_need_byte;
        n_need_post = r_need_post;
        seg_last    = 1'b0;
        o_cmd       = '0;
        o_cmd.src   = SRC_BYTE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_need_pre   = i_stat.plan_sei_pre;
                    n_need_hold  = i_stat.plan_hold;
                    n_need_byte  = i_stat.plan_byte;
                    n_need_post  = i_stat.plan_sei_post;
                    n_state      = pick(i_stat.plan_sei_pre, i_stat.plan_hold,
                                        i_stat.plan_byte, i_stat.plan_sei_post);
                end
            end
            ST_SEI: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_SEI;
                    seg_last   = i_stat.sei_last;
                    if (seg_last) begin
                        if (r_need_pre) begin
                            n_need_pre = 1'b0;
                        end else begin
                            n_need_post = 1'b0;
                        end
                    end
                end
            end
            ST_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_HOLD;
                    seg_last   = i_stat.hold_last;
                    if (seg_last) begin
                        n_need_hold = 1'b0;
                    end
                end
            end
            ST_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.src   = SRC_BYTE;
                    seg_last    = 1'b1;
                    n_need_byte = 1'b0;
                end
            end
        endcase
        after_seg = pick(n_need_pre, n_need_hold, n_need_byte, n_need_post);
        if (o_cmd.emit && seg_last) begin
            n_state         = after_seg;
            o_cmd.last_byte = (after_seg == ST_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_need_pre  <= 1'b0;
            r_need_hold <= 1'b0;
            r_need_byte <= 1'b0;
            r_need_post <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_need_pre  <= n_need_pre;
            r_need_hold <= n_need_hold;
            r_need_byte <= n_need_byte;
            r_need_post <= n_need_post;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

/* design/asi_dp.sv */
module asi_dp
    import asi_pkg::*;
#(
    parameter int SEI_DEPTH = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_kind,
    input  logic [7:0] i_byte_in,
    input  logic       i_last_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_byte_out,
    output logic       o_from_sei,
    output logic       o_packet_end,
    output logic       o_sei_dropped,
    output logic       o_run_last
);

    localparam int AW = (SEI_DEPTH > 1) ? $clog2(SEI_DEPTH) : 1;
    localparam int LW = $clog2(SEI_DEPTH + 1);

    logic [7:0]    mem [SEI_DEPTH];
    logic [7:0]    r_rd_data;

    logic          r_codec;
    t_phase        r_phase;
    logic [1:0]    r_zeros;
    logic          r_insert_done;
    logic [LW-1:0] r_sei_len;
    logic          r_ovf;

    logic [AW-1:0] r_sei_idx, n_sei_idx;
    logic [2:0]    r_hold_idx, n_hold_idx;

    logic [7:0]    r_snap_byte;
    logic [1:0]    r_snap_zeros;
    logic          r_snap_start;
    logic [2:0]    r_snap_hold_len;
    logic [LW-1:0] r_snap_sei_cnt;
    logic          r_snap_last;
    logic          r_snap_ovf;

    logic          r_out_valid;
    logic [7:0]    r_byte_out;
    logic          r_from_sei;
    logic          r_packet_end;
    logic          r_sei_dropped;
    logic          r_run_last;

    logic          is_search, is_start, is_zero, is_one, prefix;
    logic          absorb, zero_spill, sei_pre, emit_byte, flush_hold, sei_ok, sei_post;
    logic [2:0]    hold_len;
    logic          sei_last, hold_last;
    logic          pkt_accept, sei_accept;
    logic [7:0]    hold_byte, emit_data;

    // what this packet byte will cause
    assign is_search  = (r_phase != PH_START) && (r_phase != PH_PASS);
    assign is_start   = (r_phase == PH_START);
    assign is_zero    = (i_byte_in == 8'h00);
    assign is_one     = (i_byte_in == START_CODE_BYTE);
    assign prefix     = hdr_is_setup_nal(r_codec, i_byte_in);
    assign absorb     = is_search && ((is_zero && (r_zeros != HOLD_ZERO_MAX)) ||
                                      (is_one && (r_zeros >= START_MIN_ZEROS)));
    assign zero_spill = is_search && is_zero && (r_zeros == HOLD_ZERO_MAX);
    assign sei_pre    = is_start && !prefix;
    assign emit_byte  = !absorb || i_last_in;
    assign flush_hold = emit_byte && (!zero_spill || i_last_in);
    assign hold_len   = flush_hold ? ({1'b0, r_zeros} + {2'b00, is_start}) : 3'd0;
    assign sei_ok     = (r_sei_len != '0) && !r_ovf;
    assign sei_post   = i_last_in && !(r_insert_done || sei_pre);

    assign sei_last   = ((LW'(r_sei_idx) + LW'(1)) == r_snap_sei_cnt);
    assign hold_last  = ((r_hold_idx + 3'd1) == r_snap_hold_len);

    assign o_stat.plan_sei_pre  = i_kind && sei_pre && sei_ok;
    assign o_stat.plan_hold     = i_kind && (hold_len != 3'd0);
    assign o_stat.plan_byte     = i_kind && emit_byte;
    assign o_stat.plan_sei_post = i_kind && sei_post && sei_ok;
    assign o_stat.sei_last      = sei_last;
    assign o_stat.hold_last     = hold_last;
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

    assign pkt_accept = i_cmd.accept && i_kind;
    assign sei_accept = i_cmd.accept && !i_kind;

    always_comb begin
        n_sei_idx = r_sei_idx;
        if (i_cmd.accept) begin
            n_sei_idx = '0;
        end else if (i_cmd.emit && (i_cmd.src == SRC_SEI)) begin
            n_sei_idx = sei_last ? '0 : r_sei_idx + AW'(1);
        end
    end

    always_comb begin
        n_hold_idx = r_hold_idx;
        if (i_cmd.accept) begin
            n_hold_idx = 3'd0;
        end else if (i_cmd.emit && (i_cmd.src == SRC_HOLD)) begin
            n_hold_idx = hold_last ? 3'd0 : r_hold_idx + 3'd1;
        end
    end

    assign hold_byte = (r_snap_start && (r_hold_idx == {1'b0, r_snap_zeros})) ?
                       START_CODE_BYTE : 8'h00;

    always_comb begin
        unique case (i_cmd.src)
            SRC_SEI:  emit_data = r_rd_data;
            SRC_HOLD: emit_data = hold_byte;
            SRC_BYTE: emit_data = r_snap_byte;
            default:  emit_data = r_snap_byte;
        endcase
    end

    // sei buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (sei_accept && (r_sei_len < LW'(SEI_DEPTH))) begin
            mem[r_sei_len[AW-1:0]] <= i_byte_in;
        end
        r_rd_data <= mem[n_sei_idx];
    end

    // snapshot and output payload
    always_ff @(posedge i_clk) begin
        if (pkt_accept) begin
            r_snap_byte     <= i_byte_in;
            r_snap_zeros    <= r_zeros;
            r_snap_start    <= is_start;
            r_snap_hold_len <= hold_len;
            r_snap_sei_cnt  <= r_sei_len;
            r_snap_last     <= i_last_in;
            r_snap_ovf      <= r_ovf;
        end
        if (i_cmd.emit) begin
            r_byte_out    <= emit_data;
            r_from_sei    <= (i_cmd.src == SRC_SEI);
            r_packet_end  <= i_cmd.last_byte && r_snap_last;
            r_sei_dropped <= i_cmd.last_byte && r_snap_last && r_snap_ovf;
            r_run_last    <= i_cmd.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec       <= 1'b0;
            r_phase       <= PH_SEARCH;
            r_zeros       <= 2'd0;
            r_insert_done <= 1'b0;
            r_sei_len     <= '0;
            r_ovf         <= 1'b0;
            r_sei_idx     <= '0;
            r_hold_idx    <= 3'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_codec <= i_cfg_wdata;
            end
            if (sei_accept) begin
                if (r_sei_len < LW'(SEI_DEPTH)) begin
                    r_sei_len <= r_sei_len + LW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (pkt_accept) begin
                if (i_last_in) begin
                    r_phase       <= PH_SEARCH;
                    r_zeros       <= 2'd0;
                    r_insert_done <= 1'b0;
                    r_sei_len     <= '0;
                    r_ovf         <= 1'b0;
                end else begin
                    unique case (r_phase)
                        PH_PASS: begin
                        end
                        PH_START: begin
                            r_zeros <= 2'd0;
                            if (prefix) begin
                                r_phase <= PH_SEARCH;
                            end else begin
                                r_phase       <= PH_PASS;
                                r_insert_done <= 1'b1;
                            end
                        end
                        default: begin
                            r_phase <= PH_SEARCH;
                            if (is_zero) begin
                                if (r_zeros != HOLD_ZERO_MAX) begin
                                    r_zeros <= r_zeros + 2'd1;
                                end
                            end else if (absorb) begin
                                r_phase <= PH_START;
                            end else begin
                                r_zeros <= 2'd0;
                            end
                        end
                    endcase
                end
            end
            r_sei_idx  <= n_sei_idx;
            r_hold_idx <= n_hold_idx;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_out    = r_byte_out;
    assign o_from_sei    = r_from_sei;
    assign o_packet_end  = r_packet_end;
    assign o_sei_dropped = r_sei_dropped;
    assign o_run_last    = r_run_last;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sei_len <= LW'(SEI_DEPTH))
        else $error("sei length beyond buffer depth");

    a_start_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |-> (r_zeros >= START_MIN_ZEROS))
        else $error("start code held with too few zeros");

    a_pass_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PASS) |-> ((r_zeros == 2'd0) && r_insert_done))
        else $error("pass through with bytes held or no insertion");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_packet_end) |-> r_run_last)
        else $error("packet end not on last byte of item");

    a_drop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sei_dropped) |-> r_packet_end)
        else $error("drop flag away from packet end");

endmodule
